@@ rtl/core/olist_pkg.sv @@
// Shared types for the ordered list engine: command and status codes and the
// control word broadcast from the top level to every list cell.
// No dependencies.
package olist_pkg;

    typedef enum logic [2:0] {
        CMD_INS_HEAD = 3'd0,
        CMD_INS_TAIL = 3'd1,
        CMD_INS_AT   = 3'd2,
        CMD_UPDATE   = 3'd3,
        CMD_DELETE   = 3'd4,
        CMD_SEARCH   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OOB  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_INSERT = 2'd1,
        OP_UPDATE = 2'd2,
        OP_DELETE = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        cmp_en;
        logic [31:0] value;
    } t_cell_ctl;

endpackage

@@ rtl/core/ordered_list_engine.sv @@
// Ordered list engine: a list of up to CAPACITY signed 32-bit entries kept
// in a row of cells that shift together on insert and delete.
//
// Input channel (i_valid/o_stall): one transaction carries i_cmd, i_value
// and i_position. Output channel (o_valid/i_stall): one transaction per
// input transaction with o_status, o_found and o_length, in order.
//
// Throughput is one transaction per cycle while o_stall is low: every cell
// shifts, writes and compares in the acceptance cycle; the match bits are
// registered in the cells and OR-reduced in the second stage into the output
// register.
//
// When the receiver stalls, the output register holds, the middle stage
// fills, and o_stall rises until the output drains. Reset clears the entry
// count and both stage valid bits; entry contents stay undefined until
// written and are never read beyond the count.
// Depends on olist_pkg and olist_cell.
module ordered_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_cmd,
    input  logic signed [31:0] i_value,
    input  logic [5:0]  i_position,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic [6:0]  o_length
);
    import olist_pkg::*;

    localparam int CLOG = $clog2(CAPACITY + 1);
    localparam int CW   = (CLOG > 6) ? CLOG : 6;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    logic          r_s1_valid;
    t_status       r_s1_status;
    logic          r_s1_search;
    logic [6:0]    r_s1_length;

    logic          r_out_valid;
    t_status       r_out_status;
    logic          r_out_found;
    logic [6:0]    r_out_length;

    logic          w_adv;
    logic          w_accept;
    t_status       w_status;
    t_op           w_op;
    logic [CW-1:0] w_pos;
    logic [CW-1:0] w_pos_in;
    t_cell_ctl     w_ctl;

    logic [31:0]         w_data [CAPACITY];
    logic [CAPACITY-1:0] w_match;

    assign w_adv    = !r_out_valid || !i_stall;
    assign o_stall  = r_s1_valid && !w_adv;
    assign w_accept = i_valid && !o_stall;
    assign w_pos_in = {{(CW-6){1'b0}}, i_position};

    // decode the command against the current count
    always_comb begin
        w_status = ST_OK;
        w_op     = OP_NONE;
        w_pos    = w_pos_in;
        n_count  = r_count;
        case (t_cmd'(i_cmd))
            CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
                if (t_cmd'(i_cmd) == CMD_INS_HEAD) begin
                    w_pos = '0;
                end else if (t_cmd'(i_cmd) == CMD_INS_TAIL) begin
                    w_pos = r_count;
                end
                if (r_count >= CAP_C) begin
                    w_status = ST_FULL;
                end else if (w_pos > r_count) begin
                    w_status = ST_OOB;
                end else begin
                    w_op    = OP_INSERT;
                    n_count = r_count + CW'(1);
                end
            end
            CMD_UPDATE: begin
                if (w_pos_in >= r_count) begin
                    w_status = ST_OOB;
                end else begin
                    w_op = OP_UPDATE;
                end
            end
            CMD_DELETE: begin
                if (w_pos_in >= r_count) begin
                    w_status = ST_OOB;
                end else begin
                    w_op    = OP_DELETE;
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    assign w_ctl.op     = w_accept ? w_op : OP_NONE;
    assign w_ctl.cmp_en = w_accept;
    assign w_ctl.value  = i_value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [31:0] w_left;
        logic [31:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_inner
            assign w_right = w_data[g+1];
        end
        olist_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pos   (w_pos),
            .i_count (r_count),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g]),
            .o_match (w_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (!o_stall) begin
                r_s1_valid <= w_accept;
            end
        end
        // payload: no reset
        if (w_accept) begin
            r_s1_status <= w_status;
            r_s1_search <= (t_cmd'(i_cmd) == CMD_SEARCH);
            r_s1_length <= 7'(n_count);
        end
        if (w_adv && r_s1_valid) begin
            r_out_status <= r_s1_status;
            r_out_found  <= r_s1_search && (|w_match);
            r_out_length <= r_s1_length;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_found  = r_out_found;
    assign o_length = r_out_length;

endmodule

@@ rtl/core/olist_cell.sv @@
// One list cell: holds one entry, shifts with its neighbors on insert and
// delete, and registers a compare against the broadcast value.
// Depends on olist_pkg.
module olist_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                  i_clk,
    input  olist_pkg::t_cell_ctl  i_ctl,
    input  logic [CW-1:0]         i_pos,
    input  logic [CW-1:0]         i_count,
    input  logic [31:0]           i_left,
    input  logic [31:0]           i_right,
    output logic [31:0]           o_data,
    output logic                  o_match
);
    import olist_pkg::*;

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [31:0] r_data;
    logic [31:0] n_data;
    logic        r_match;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            OP_INSERT: begin
                if (IDX_C == i_pos) begin
                    n_data = i_ctl.value;
                end else if (IDX_C > i_pos) begin
                    n_data = i_left;
                end
            end
            OP_UPDATE: begin
                if (IDX_C == i_pos) begin
                    n_data = i_ctl.value;
                end
            end
            OP_DELETE: begin
                // close the gap: take the entry from the right neighbor
                if (IDX_C >= i_pos) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (i_ctl.cmp_en) begin
            r_match <= (IDX_C < i_count) && (r_data == i_ctl.value);
        end
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule
